### sv/integer_to_radix_ascii_top_macros.svh
// Assertion macros shared by the integer to radix ASCII block.
// Depends on nothing; included by the top level only.
`ifndef INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define IRA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_radix_ascii: assertion failed");
`define IRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_radix_ascii: assertion failed");
`else
`define IRA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/ira_pkg.sv
// Shared constants, types and helper functions of the integer to radix ASCII block.
// Depends on nothing; used by the front end, the back end and the top level of the block.
package ira_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;

    localparam int IN_VALUE_W = 64;
    localparam int OP_W       = 3;
    localparam int CHAR_W     = 7;
    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);

    localparam int STEP_BITS = 8;
    localparam int STEPS     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QUO_W     = STEPS * STEP_BITS;
    localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [1:0] TYPE_8  = 2'd0;
    localparam logic [1:0] TYPE_16 = 2'd1;
    localparam logic [1:0] TYPE_32 = 2'd2;
    localparam logic [1:0] TYPE_64 = 2'd3;
    localparam int OP_SIGNED_BIT = 2;

    localparam logic [BASE_W-1:0] DEFAULT_BASE = BASE_W'(10);
    localparam logic [BASE_W-1:0] MIN_BASE     = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE     = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(8'h57);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic                   neg;
        logic [BASE_W-1:0]      base;
    } t_job;

    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        if (b < MIN_BASE || b > MAX_BASE) begin
            return DEFAULT_BASE;
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_ALPHA + CHAR_W'(d);
    endfunction

endpackage

### sv/ira_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing; holds the digit store of the back end.
module ira_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ira_front.sv
// Front end: takes input words, classifies type and sign, queues magnitude jobs.
// Also holds the base register. Depends on ira_pkg.
module ira_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ira_pkg::OP_W-1:0]      i_op,
    input  logic [ira_pkg::IN_VALUE_W-1:0] i_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ira_pkg::BASE_W-1:0]    i_cfg_data,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output ira_pkg::t_job                 o_job
);
    import ira_pkg::*;

    logic [BASE_W-1:0] r_base;
    t_job              r_q [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;

    logic        w_push_acc;
    logic        w_deq;
    logic [63:0] w_raw;
    logic [63:0] w_mask;
    logic [63:0] w_v;
    logic [63:0] w_mag;
    logic        w_sign;
    logic        w_neg;
    t_job        w_job;

    always_comb begin
        w_raw = 64'(i_value[VALUE_WIDTH-1:0]);
        unique case (i_op[1:0])
            TYPE_8: begin
                w_mask = 64'h0000_0000_0000_00ff;
            end
            TYPE_16: begin
                w_mask = 64'h0000_0000_0000_ffff;
            end
            TYPE_32: begin
                w_mask = 64'h0000_0000_ffff_ffff;
            end
            default: begin
                w_mask = 64'hffff_ffff_ffff_ffff;
            end
        endcase
        w_v = w_raw & w_mask;
        unique case (i_op[1:0])
            TYPE_8: begin
                w_sign = w_v[7];
            end
            TYPE_16: begin
                w_sign = w_v[15];
            end
            TYPE_32: begin
                w_sign = w_v[31];
            end
            default: begin
                w_sign = w_v[63];
            end
        endcase
        w_neg = i_op[OP_SIGNED_BIT] & w_sign;
        w_mag = w_neg ? ((64'd0 - w_v) & w_mask) : w_v;
        w_job.mag  = w_mag[VALUE_WIDTH-1:0];
        w_job.neg  = w_neg;
        w_job.base = eff_base(r_base);
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cfg_ready = 1'b1;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];
    assign w_push_acc  = push & ~full;
    assign w_deq       = o_job_valid & i_job_ready;

    always_ff @(posedge i_clk) begin
        if (w_push_acc) begin
            r_q[r_wr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= DEFAULT_BASE;
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (w_push_acc) begin
                r_wr <= ~r_wr;
            end
            if (w_deq) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push_acc) - 2'(w_deq);
        end
    end

endmodule

### sv/ira_back.sv
// Back end: divides each magnitude by the base, stores digits, emits them as ASCII.
// Depends on ira_pkg and ira_ram.
module ira_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  ira_pkg::t_job              i_job,
    output logic                       empty,
    input  logic                       pop,
    output logic [ira_pkg::CHAR_W-1:0] o_digit_char,
    output logic                       o_negative,
    output logic                       o_last
);
    import ira_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DIV     = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_WT = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [QUO_W-1:0]   r_quo;
    logic [QUO_W-1:0]   n_quo;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] n_rem;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [BASE_W-1:0]  r_base;
    logic [BASE_W-1:0]  n_base;
    logic               r_neg;
    logic               n_neg;
    logic               r_first;
    logic               n_first;
    logic               r_ov;
    logic               n_ov;
    logic [CHAR_W-1:0]  r_char;
    logic [CHAR_W-1:0]  n_char;
    logic               r_oneg;
    logic               n_oneg;
    logic               r_olast;
    logic               n_olast;

    logic [STEP_BITS-1:0] w_byte;
    logic [STEP_BITS-1:0] w_qbyte;
    logic [DIGIT_W-1:0]   w_rem;
    logic [DIGIT_W:0]     w_trial;
    logic [QUO_W-1:0]     w_quo_next;
    logic [CNT_W-1:0]     w_cnt_inc;
    logic                 w_we;
    logic                 w_re;
    logic [ADDR_W-1:0]    w_raddr;
    logic [DIGIT_W-1:0]   w_rdata;
    logic                 w_pop_acc;

    ira_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(w_rem),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // One byte of the quotient is worked off per cycle by restoring long division.
    always_comb begin
        w_byte  = r_quo[QUO_W-1 -: STEP_BITS];
        w_rem   = r_rem;
        w_qbyte = '0;
        w_trial = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            w_trial = {w_rem, w_byte[i]};
            if (w_trial >= (DIGIT_W + 1)'(r_base)) begin
                w_qbyte[i] = 1'b1;
                w_trial    = w_trial - (DIGIT_W + 1)'(r_base);
            end
            w_rem = w_trial[DIGIT_W-1:0];
        end
        w_quo_next = QUO_W'({r_quo, w_qbyte});
    end

    assign w_cnt_inc   = r_cnt + CNT_W'(1);
    assign w_pop_acc   = pop & r_ov;
    assign w_raddr     = ADDR_W'(r_cnt - CNT_W'(1));
    assign w_we        = (r_state == ST_DIV) && (r_step == STEP_W'(STEPS - 1));
    assign w_re        = (r_state == ST_EMIT_RD);
    assign o_job_ready = (r_state == ST_IDLE);
    assign empty        = ~r_ov;
    assign o_digit_char = r_char;
    assign o_negative   = r_oneg;
    assign o_last       = r_olast;

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_base  = r_base;
        n_neg   = r_neg;
        n_first = r_first;
        n_ov    = r_ov & ~w_pop_acc;
        n_char  = r_char;
        n_oneg  = r_oneg;
        n_olast = r_olast;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_quo   = QUO_W'(i_job.mag);
                    n_neg   = i_job.neg;
                    n_base  = i_job.base;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_first = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo = w_quo_next;
                n_rem = w_rem;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_step = '0;
                    n_rem  = '0;
                    n_cnt  = w_cnt_inc;
                    if (w_quo_next == '0 || w_cnt_inc == CNT_W'(MAX_DIGITS)) begin
                        n_state = ST_EMIT_RD;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WT;
            end
            ST_EMIT_WT: begin
                if (!r_ov || w_pop_acc) begin
                    n_ov    = 1'b1;
                    n_char  = digit_to_char(w_rdata);
                    n_oneg  = r_first & r_neg;
                    n_olast = (r_cnt == CNT_W'(1));
                    n_first = 1'b0;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = (r_cnt == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_base  <= n_base;
        r_neg   <= n_neg;
        r_first <= n_first;
        r_char  <= n_char;
        r_oneg  <= n_oneg;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

endmodule

### sv/integer_to_radix_ascii_top.sv
// Top level of the integer to radix ASCII block: front end, job queue, back end.
// Depends on ira_pkg, ira_front, ira_back and the assertion macro header.
//
// Channel   Direction  Handshake                 Payload
// input     in         push / full               i_op, i_value
// result    out        empty / pop               o_digit_char, o_negative, o_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (number base)
//
// A number is started from the idle state, divided one digit at a time (one quotient
// byte per cycle), then sent out one character at a time through the digit store read port.
// The front end queues up to two further words while the back end is busy.
// Reset is synchronous and active low; the base returns to ten.
// A stalled result holds the back end in its emit loop; the front keeps accepting until its queue is full.
`include "integer_to_radix_ascii_top_macros.svh"

module integer_to_radix_ascii_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ira_pkg::OP_W-1:0]       i_op,
    input  logic [ira_pkg::IN_VALUE_W-1:0] i_value,
    output logic                           empty,
    input  logic                           pop,
    output logic [ira_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_negative,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ira_pkg::BASE_W-1:0]     i_cfg_data
);
    import ira_pkg::*;

    logic w_job_valid;
    logic w_job_ready;
    t_job w_job;

    ira_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_job_valid(w_job_valid),
        .i_job_ready(w_job_ready),
        .o_job      (w_job)
    );

    ira_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .empty       (empty),
        .pop         (pop),
        .o_digit_char(o_digit_char),
        .o_negative  (o_negative),
        .o_last      (o_last)
    );

    `IRA_ASSERT_SAME(a_char_range, i_clk, i_rst_n, !empty,
        (o_digit_char >= 7'h30 && o_digit_char <= 7'h39) ||
        (o_digit_char >= 7'h61 && o_digit_char <= 7'h66))
    `IRA_ASSERT_NEXT(a_sign_first_only, i_clk, i_rst_n, pop && !empty && !o_last,
        empty || !o_negative)

endmodule
